// File: hdl/jsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Word types, controller/datapath interface and constants for the JSON string
// unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last_item;
        logic [15:0] bytes_written;
        logic [15:0] utf16_units;
        logic        truncated;
    } t_out_word;

    typedef struct packed {
        logic accept;
        logic step;
        logic load_byte;
        logic load_sum;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic need;
        logic write_go;
        logic last_idx;
        logic out_free;
        logic at_end;
    } t_stat;

    localparam int PEND_DEPTH  = 6;
    localparam int MAX_RESULTS = 12;

    localparam logic [1:0] K_NEED = 2'd0;
    localparam logic [1:0] K_EMIT = 2'd1;
    localparam logic [1:0] K_HELD = 2'd2;

    localparam logic M_IDLE = 1'b0;
    localparam logic M_HIGH = 1'b1;

    localparam logic [1:0] H_NEED = 2'd0;
    localparam logic [1:0] H_BAD  = 2'd1;
    localparam logic [1:0] H_OK   = 2'd2;

    localparam logic [20:0] CP_REPL    = 21'h00fffd;
    localparam logic [20:0] CP_MAX     = 21'h10ffff;
    localparam logic [20:0] CP_SUPP    = 21'h010000;
    localparam logic [15:0] LOW_FIRST  = 16'hdc00;
    localparam logic [15:0] LOW_LAST   = 16'hdfff;
    localparam logic [15:0] HIGH_FIRST = 16'hd800;
    localparam logic [15:0] HIGH_LAST  = 16'hdbff;

    localparam logic [7:0] CH_BSL = 8'h5c;
    localparam logic [7:0] CH_U   = 8'h75;
    localparam logic [7:0] CH_B   = 8'h62;
    localparam logic [7:0] CH_F   = 8'h66;
    localparam logic [7:0] CH_N   = 8'h6e;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_T   = 8'h74;

endpackage
`default_nettype wire

// File: hdl/json_string_unescape_utf8_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// JSON string body unescaper with UTF-8 re-encoding and closing totals.
// ----------------------------------------------------------------------------
// Each input byte is accepted, then decoded in passes over the six-byte
// pending window until a closing pass finds nothing left to decide; each
// pass writes any UTF-8 bytes it yields through the output register. A
// closing byte then adds the summary word. The sequencer steps the single
// shared decoder once per pass, and output stalls hold the sequencer.
module json_string_unescape_utf8_core #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire jsu_pkg::t_in_word  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output jsu_pkg::t_out_word      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [15:0]        i_cfg_data
);
    import jsu_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    jsu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    jsu_dp #(.COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire

// File: hdl/jsu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_ctrl
// Sequencer: accept a byte, run decode passes, emit bytes, close the string.
// ----------------------------------------------------------------------------
module jsu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_cfg_ready,
    input  wire jsu_pkg::t_stat i_stat,
    output jsu_pkg::t_cmd      o_cmd
);
    import jsu_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [1:0] S_SUM  = 2'd3;

    logic [1:0] r_state, n_state;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step      = (r_state == S_DEC) && i_stat.active && !i_stat.need;
        o_cmd.load_byte = (r_state == S_EMIT) && i_stat.out_free;
        o_cmd.load_sum  = (r_state == S_SUM) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DEC;
            S_DEC: begin
                if (!i_stat.active || i_stat.need) begin
                    n_state = i_stat.at_end ? S_SUM : S_IDLE;
                end else if (i_stat.write_go) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: if (i_stat.out_free && i_stat.last_idx) n_state = S_DEC;
            S_SUM:  if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule
`default_nettype wire

// File: hdl/jsu_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_dp
// Pending byte window, decoder, UTF-8 encoder, counters and output register.
// ----------------------------------------------------------------------------
module jsu_dp #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire jsu_pkg::t_in_word i_in_data,
    input  wire logic              i_cfg_we,
    input  wire logic [15:0]       i_cfg_data,
    input  wire jsu_pkg::t_cmd     i_cmd,
    output jsu_pkg::t_stat         o_stat,
    output logic                   o_out_valid,
    output jsu_pkg::t_out_word     o_out_data,
    input  wire logic              i_out_stall
);
    import jsu_pkg::*;

    localparam int CB = COUNT_BITS;
    localparam int W  = ((CB > 16) ? CB : 16) + 1;
    localparam logic [W-1:0] CMAX = W'((64'd1 << CB) - 64'd1);

    logic [7:0]    r_buf [PEND_DEPTH];
    logic [2:0]    r_cnt;
    logic          r_mode;
    logic [15:0]   r_hs;
    logic [CB-1:0] r_written, r_units;
    logic          r_stop, r_at_end;
    logic [3:0]    r_nres;
    logic [7:0]    r_enc [4];
    logic [1:0]    r_idx, r_last;
    logic [15:0]   r_cap;
    logic          r_ovalid;
    t_out_word     r_odata, n_odata;

    logic [1:0]  d_kind, hr;
    logic [20:0] d_cp;
    logic [2:0]  d_used, len;
    logic        d_mode;
    logic [15:0] d_hs, hv;
    logic [3:0]  hnib [4];
    logic [3:0]  hok;
    logic        done, hdone, need, paired;
    logic [7:0]  e [4];
    logic [2:0]  en;
    logic        fits, out_free;
    logic [W-1:0] wsum;
    logic [CB:0]  usum;
    logic [4:0]   rsum;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic [7:0] c;
            c = r_buf[i+2];
            hok[i]  = 1'b1;
            hnib[i] = c[3:0];
            if (c >= 8'h30 && c <= 8'h39)      hnib[i] = c[3:0];
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
                hnib[i] = c[3:0] + 4'd9;
            else                                hok[i] = 1'b0;
        end
        hr    = H_OK;
        hdone = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (!hdone) begin
                if (4'(i + 2) >= {1'b0, r_cnt}) begin
                    hr = r_at_end ? H_BAD : H_NEED; hdone = 1'b1;
                end else if (!hok[i]) begin
                    hr = H_BAD; hdone = 1'b1;
                end
            end
        end
        hv = {hnib[0], hnib[1], hnib[2], hnib[3]};
    end

    always_comb begin
        d_kind = K_NEED; d_cp = '0; d_used = '0; d_mode = r_mode; d_hs = r_hs;
        need = 1'b0; paired = 1'b0; len = 3'd1; done = 1'b0;
        if (r_mode == M_HIGH) begin
            if (r_cnt < 3'd1) need = !r_at_end;
            else if (r_buf[0] == CH_BSL) begin
                if (r_cnt < 3'd2) need = !r_at_end;
                else if (r_buf[1] == CH_U) begin
                    if (hr == H_NEED) need = 1'b1;
                    else if (hr == H_OK && hv >= LOW_FIRST && hv <= LOW_LAST) paired = 1'b1;
                end
            end
            if (!need) begin
                d_kind = K_EMIT; d_mode = M_IDLE;
                if (paired) begin
                    d_cp = {1'b0, r_hs[9:0], hv[9:0]} + CP_SUPP;
                    d_used = 3'd6;
                end else begin
                    d_cp = {5'd0, r_hs};
                end
            end
        end else if (r_buf[0] != CH_BSL) begin
            d_kind = K_EMIT; d_used = 3'd1; d_cp = CP_REPL;
            if (!r_buf[0][7]) d_cp = {13'd0, r_buf[0]};
            else begin
                if (r_buf[0][7:5] == 3'b110)      len = 3'd2;
                else if (r_buf[0][7:4] == 4'hE)   len = 3'd3;
                else if (r_buf[0][7:3] == 5'h1E)  len = 3'd4;
                else                              done = 1'b1;
                for (int i = 1; i < 4; i++) begin
                    if (!done && 3'(i) < len) begin
                        if (3'(i) >= r_cnt) begin
                            done = 1'b1;
                            if (!r_at_end) d_kind = K_NEED;
                        end else if (r_buf[i][7:6] != 2'b10) done = 1'b1;
                    end
                end
                if (!done) begin
                    d_used = len;
                    unique case (len)
                        3'd2: d_cp = {10'd0, r_buf[0][4:0], r_buf[1][5:0]};
                        3'd3: d_cp = {5'd0, r_buf[0][3:0], r_buf[1][5:0], r_buf[2][5:0]};
                        default: d_cp = {r_buf[0][2:0], r_buf[1][5:0], r_buf[2][5:0],
                                         r_buf[3][5:0]};
                    endcase
                end
            end
        end else if (r_cnt < 3'd2) begin
            if (r_at_end) begin d_kind = K_EMIT; d_cp = CP_REPL; d_used = 3'd1; end
        end else begin
            d_kind = K_EMIT; d_used = 3'd2;
            unique case (r_buf[1])
                CH_B: d_cp = 21'h08;
                CH_F: d_cp = 21'h0c;
                CH_N: d_cp = 21'h0a;
                CH_R: d_cp = 21'h0d;
                CH_T: d_cp = 21'h09;
                CH_U: begin
                    if (hr == H_NEED) d_kind = K_NEED;
                    else if (hr == H_BAD) d_cp = CP_REPL;
                    else begin
                        d_used = 3'd6;
                        if (hv >= HIGH_FIRST && hv <= HIGH_LAST) begin
                            d_kind = K_HELD; d_hs = hv; d_mode = M_HIGH;
                        end else d_cp = {5'd0, hv};
                    end
                end
                default: d_cp = {13'd0, r_buf[1]};
            endcase
        end
        if (d_used > r_cnt) d_used = r_cnt;
    end

    always_comb begin
        e[0] = 8'hef; e[1] = 8'hbf; e[2] = 8'hbd; e[3] = 8'h00; en = 3'd3;
        if (d_cp <= 21'h7f) begin
            e[0] = d_cp[7:0]; en = 3'd1;
        end else if (d_cp <= 21'h7ff) begin
            e[0] = {3'b110, d_cp[10:6]}; e[1] = {2'b10, d_cp[5:0]}; en = 3'd2;
        end else if (d_cp <= 21'hffff) begin
            e[0] = {4'hE, d_cp[15:12]}; e[1] = {2'b10, d_cp[11:6]};
            e[2] = {2'b10, d_cp[5:0]};
        end else if (d_cp <= CP_MAX) begin
            e[0] = {5'h1E, d_cp[20:18]}; e[1] = {2'b10, d_cp[17:12]};
            e[2] = {2'b10, d_cp[11:6]};  e[3] = {2'b10, d_cp[5:0]}; en = 3'd4;
        end
        wsum = W'(r_written) + W'(en);
        usum = {1'b0, r_units} + ((d_cp > 21'hffff) ? (CB+1)'(2) : (CB+1)'(1));
        rsum = 5'(en) + 5'(r_nres) + 5'(r_at_end);
        fits = (wsum < W'(r_cap)) && (wsum <= CMAX) && (rsum <= 5'(MAX_RESULTS));
    end

    assign out_free = !r_ovalid || !i_out_stall;

    always_comb begin
        o_stat.active   = (r_mode == M_HIGH) || (r_cnt != 3'd0);
        o_stat.need     = (d_kind == K_NEED);
        o_stat.write_go = (d_kind == K_EMIT) && !r_stop && fits;
        o_stat.last_idx = (r_idx == r_last);
        o_stat.out_free = out_free;
        o_stat.at_end   = r_at_end;
    end

    always_comb begin
        n_odata = r_odata;
        if (i_cmd.load_byte) begin
            n_odata            = '0;
            n_odata.out_byte   = r_enc[r_idx];
            n_odata.byte_valid = 1'b1;
        end else if (i_cmd.load_sum) begin
            n_odata               = '0;
            n_odata.last_item     = 1'b1;
            n_odata.bytes_written = 16'(r_written);
            n_odata.utf16_units   = 16'(r_units);
            n_odata.truncated     = r_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_cnt < 3'(PEND_DEPTH)) r_buf[r_cnt] <= i_in_data.in_byte;
        if (i_cmd.step) begin
            for (int i = 0; i < PEND_DEPTH; i++) begin
                if (i + int'(d_used) < PEND_DEPTH) r_buf[i] <= r_buf[i + int'(d_used)];
            end
            if (o_stat.write_go) begin
                for (int i = 0; i < 4; i++) r_enc[i] <= e[i];
                r_idx  <= '0;
                r_last <= 2'(en - 3'd1);
            end
        end
        if (i_cmd.load_byte) begin
            r_idx <= r_idx + 2'd1;
        end
        r_odata <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_mode <= M_IDLE; r_hs <= '0; r_written <= '0; r_units <= '0;
            r_stop <= 1'b0; r_at_end <= 1'b0; r_nres <= '0; r_ovalid <= 1'b0;
            r_cap <= 16'hffff;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (i_cmd.accept) begin
                r_at_end <= i_in_data.end_of_string;
                r_nres   <= '0;
                if (r_cnt < 3'(PEND_DEPTH)) r_cnt <= r_cnt + 3'd1;
            end
            if (i_cmd.step) begin
                r_cnt  <= r_cnt - d_used;
                r_mode <= d_mode;
                r_hs   <= d_hs;
                if (d_kind == K_EMIT) begin
                    r_units <= usum[CB] ? CMAX[CB-1:0] : usum[CB-1:0];
                    if (!r_stop && fits) r_written <= wsum[CB-1:0];
                    if (!fits)           r_stop    <= 1'b1;
                end
            end
            if (i_cmd.load_byte) r_nres <= r_nres + 4'd1;
            if (i_cmd.load_byte || i_cmd.load_sum) r_ovalid <= 1'b1;
            else if (!i_out_stall)                 r_ovalid <= 1'b0;
            if (i_cmd.load_sum) begin
                r_cnt <= '0; r_mode <= M_IDLE; r_hs <= '0; r_written <= '0;
                r_units <= '0; r_stop <= 1'b0; r_at_end <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

`ifndef SYNTHESIS
    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= 4'(MAX_RESULTS)) else $error("result budget exceeded");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(PEND_DEPTH)) else $error("pending window overflow");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_byte || i_cmd.load_sum) |-> out_free)
        else $error("output register overwritten");
    a_sum_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_sum |=> (r_cnt == 3'd0 && !r_stop && r_written == '0))
        else $error("string state not cleared");
`endif

endmodule
`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for json_string_unescape_utf8_core: drives string bodies as input
// words, predicts the UTF-8 output words and closing totals, and compares
// every output word field by field.
// ----------------------------------------------------------------------------
module tb;
    import jsu_pkg::*;

    localparam int CNT_MAX = 65535;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    json_string_unescape_utf8_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predictor state
    int unsigned capacity = 65535;
    logic        mode_high = 1'b0;
    logic [7:0]  win [PEND_DEPTH];
    int unsigned win_cnt = 0;
    int unsigned high_sur = 0;
    int unsigned wr_cnt = 0;
    int unsigned unit_cnt = 0;
    logic        stopped = 1'b0;

    t_out_word   expected_words[$];
    int          n_errors = 0;
    bit          idle_on = 1'b1;

    task automatic report(input string what, input t_out_word got, input t_out_word exp);
        $display("MISMATCH %s: got %h expected %h", what, got, exp);
        n_errors++;
    endtask

    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    // 1 ok, 0 bad, -1 need more
    function automatic int hex4(input int unsigned start, input bit at_end,
                                output int unsigned v);
        int h;
        v = 0;
        for (int i = 0; i < 4; i++) begin
            if (start + i >= win_cnt || start + i >= PEND_DEPTH) return at_end ? 0 : -1;
            h = hex_val(win[start + i]);
            if (h < 0) return 0;
            v = (v << 4) | h;
        end
        return 1;
    endfunction

    function automatic logic [1:0] decode(input bit at_end, output int unsigned cp,
                                          output int unsigned used);
        int unsigned v, len;
        int r;
        bit paired;
        cp = 0;
        used = 0;
        v = 0;
        if (mode_high) begin
            paired = 0;
            if (win_cnt < 1) begin
                if (!at_end) return K_NEED;
            end else if (win[0] == CH_BSL) begin
                if (win_cnt < 2) begin
                    if (!at_end) return K_NEED;
                end else if (win[1] == CH_U) begin
                    r = hex4(2, at_end, v);
                    if (r < 0) return K_NEED;
                    if (r > 0 && v >= LOW_FIRST && v <= LOW_LAST) paired = 1;
                end
            end
            mode_high = M_IDLE;
            if (paired) begin
                cp = 32'h10000 + ((high_sur - HIGH_FIRST) << 10) + (v - LOW_FIRST);
                used = 6;
            end else begin
                cp = high_sur;
            end
            return K_EMIT;
        end
        if (win[0] != CH_BSL) begin
            used = 1;
            if (win[0] < 8'h80) begin
                cp = win[0];
                return K_EMIT;
            end
            if ((win[0] & 8'he0) == 8'hc0) len = 2;
            else if ((win[0] & 8'hf0) == 8'he0) len = 3;
            else if ((win[0] & 8'hf8) == 8'hf0) len = 4;
            else begin
                cp = CP_REPL;
                return K_EMIT;
            end
            for (int i = 1; i < len; i++) begin
                if (i >= win_cnt) begin
                    if (!at_end) return K_NEED;
                    cp = CP_REPL;
                    return K_EMIT;
                end
                if ((win[i] & 8'hc0) != 8'h80) begin
                    cp = CP_REPL;
                    return K_EMIT;
                end
            end
            if (len == 2) v = (win[0] & 8'h1f) << 6;
            else if (len == 3) v = (win[0] & 8'h0f) << 12;
            else v = (win[0] & 8'h07) << 18;
            for (int i = 1; i < len; i++) v |= (win[i] & 8'h3f) << (6 * (len - 1 - i));
            cp = v;
            used = len;
            return K_EMIT;
        end
        if (win_cnt < 2) begin
            if (!at_end) return K_NEED;
            cp = CP_REPL;
            used = 1;
            return K_EMIT;
        end
        used = 2;
        case (win[1])
            CH_B: begin cp = 8'h08; return K_EMIT; end
            CH_F: begin cp = 8'h0c; return K_EMIT; end
            CH_N: begin cp = 8'h0a; return K_EMIT; end
            CH_R: begin cp = 8'h0d; return K_EMIT; end
            CH_T: begin cp = 8'h09; return K_EMIT; end
            CH_U: ;
            default: begin cp = win[1]; return K_EMIT; end
        endcase
        r = hex4(2, at_end, v);
        if (r < 0) return K_NEED;
        if (r == 0) begin
            cp = CP_REPL;
            return K_EMIT;
        end
        used = 6;
        if (v >= HIGH_FIRST && v <= HIGH_LAST) begin
            high_sur = v;
            mode_high = M_HIGH;
            return K_HELD;
        end
        cp = v;
        return K_EMIT;
    endfunction

    function automatic void push_word(input logic [7:0] b, input logic vld,
                                      input logic lst, input logic [15:0] bw,
                                      input logic [15:0] un, input logic tr);
        t_out_word w;
        w.out_byte = b;
        w.byte_valid = vld;
        w.last_item = lst;
        w.bytes_written = bw;
        w.utf16_units = un;
        w.truncated = tr;
        expected_words.push_back(w);
    endfunction

    function automatic void encode_cp(input int unsigned cp, input bit at_end,
                                      inout int nres);
        logic [7:0] enc[4];
        int unsigned n;
        int slots;
        unit_cnt = (unit_cnt + (cp > 32'hffff ? 2 : 1) > CNT_MAX) ? CNT_MAX :
                   unit_cnt + (cp > 32'hffff ? 2 : 1);
        if (cp <= 32'h7f) begin
            enc[0] = 8'(cp); n = 1;
        end else if (cp <= 32'h7ff) begin
            enc[0] = 8'(32'hc0 | (cp >> 6)); enc[1] = 8'(32'h80 | (cp & 32'h3f)); n = 2;
        end else if (cp <= 32'hffff) begin
            enc[0] = 8'(32'he0 | (cp >> 12)); enc[1] = 8'(32'h80 | ((cp >> 6) & 32'h3f));
            enc[2] = 8'(32'h80 | (cp & 32'h3f)); n = 3;
        end else if (cp <= CP_MAX) begin
            enc[0] = 8'(32'hf0 | (cp >> 18)); enc[1] = 8'(32'h80 | ((cp >> 12) & 32'h3f));
            enc[2] = 8'(32'h80 | ((cp >> 6) & 32'h3f));
            enc[3] = 8'(32'h80 | (cp & 32'h3f)); n = 4;
        end else begin
            enc[0] = 8'hef; enc[1] = 8'hbf; enc[2] = 8'hbd; n = 3;
        end
        if (stopped) return;
        slots = MAX_RESULTS - nres - (at_end ? 1 : 0);
        if (wr_cnt + n >= capacity || wr_cnt + n > CNT_MAX || int'(n) > slots) begin
            stopped = 1'b1;
            return;
        end
        for (int i = 0; i < n; i++) begin
            push_word(enc[i], 1'b1, 1'b0, '0, '0, 1'b0);
            nres++;
        end
        wr_cnt += n;
    endfunction

    function automatic void clear_string();
        mode_high = M_IDLE;
        win_cnt = 0;
        high_sur = 0;
        wr_cnt = 0;
        unit_cnt = 0;
        stopped = 1'b0;
    endfunction

    function automatic void predict_word(input t_in_word w);
        int nres;
        int unsigned cp, used;
        logic [1:0] k;
        nres = 0;
        if (win_cnt < PEND_DEPTH) begin
            win[win_cnt] = w.in_byte;
            win_cnt++;
        end
        while (mode_high || win_cnt > 0) begin
            k = decode(w.end_of_string, cp, used);
            if (k == K_NEED) break;
            if (used > win_cnt) used = win_cnt;
            for (int i = 0; i + used < PEND_DEPTH; i++) win[i] = win[i + used];
            win_cnt -= used;
            if (k == K_EMIT) encode_cp(cp, w.end_of_string, nres);
        end
        if (w.end_of_string) begin
            push_word(8'h00, 1'b0, 1'b1, 16'(wr_cnt), 16'(unit_cnt), stopped);
            clear_string();
        end
    endfunction

    // output checker and stall generator
    always @(posedge i_clk) begin
        t_out_word exp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report("unexpected word", o_out_data, '0);
            end else begin
                exp = expected_words.pop_front();
                if (o_out_data.out_byte !== exp.out_byte)
                    report("out_byte", o_out_data, exp);
                else if (o_out_data.byte_valid !== exp.byte_valid)
                    report("byte_valid", o_out_data, exp);
                else if (o_out_data.last_item !== exp.last_item)
                    report("last_item", o_out_data, exp);
                else if (o_out_data.bytes_written !== exp.bytes_written)
                    report("bytes_written", o_out_data, exp);
                else if (o_out_data.utf16_units !== exp.utf16_units)
                    report("utf16_units", o_out_data, exp);
                else if (o_out_data.truncated !== exp.truncated)
                    report("truncated", o_out_data, exp);
            end
        end
    end

    initial begin
        int burst;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 18);
                i_out_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        t_in_word w;
        int gap;
        w.in_byte = b;
        w.end_of_string = eos;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall);
        predict_word(w);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_text_nc(input string s, input logic eos);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], eos && i == s.len() - 1);
    endtask

    task automatic drain();
        int guard;
        i_in_valid <= 1'b0;
        guard = 0;
        while (expected_words.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [15:0] cap);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        capacity = cap;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_escapes();
        send_text("a\\\"\\\\\\/\\b\\f\\n\\r\\t\\q");
        send_text("\\u00e9\\u20AC\\uFFFF\\u0000");
        send_text("\\ud83d\\ude00");
        send_text("\\uD800x");
        send_text("\\udbff\\u0041");
        send_text("\\u12g4");
        send_text("\\u12");
        send_text("\\");
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
    endtask

    task automatic test_utf8();
        send_text("\xc3\xa9\xe2\x82\xac\xf0\x9f\x98\x80");
        send_text("\xf7\xbf\xbf\xbf");
        send_text("\xc3A\x80\xf8");
        send_text("\xe2\x82");
    endtask

    task automatic test_capacity();
        set_capacity(16'd1);
        send_text("abc");
        set_capacity(16'd4);
        send_text("ab\xe2\x82\xacz");
        set_capacity(16'd0);
        send_text("xy");
        set_capacity(16'd65535);
        send_text("\\ud83d\\ude00\\ud83d\\ude00\\ud83d\\ude00\\ud83d\\ude00");
    endtask

    function automatic logic [7:0] rand_hex();
        string hx;
        hx = "0123456789abcdefABCDEF";
        return hx[$urandom_range(0, 21)];
    endfunction

    task automatic send_random_string();
        int len, kind;
        int unsigned cp;
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: send_byte(8'($urandom_range(32, 126)), 1'b0);
                2: begin
                    cp = $urandom_range(12'h080, 16'hffff);
                    send_byte(8'(32'he0 | (cp >> 12)), 1'b0);
                    send_byte(8'(32'h80 | ((cp >> 6) & 32'h3f)), 1'b0);
                    send_byte(8'(32'h80 | (cp & 32'h3f)), 1'b0);
                end
                3: begin
                    send_byte(8'(32'hf0 | $urandom_range(0, 7)), 1'b0);
                    repeat (3) send_byte(8'(32'h80 | $urandom_range(0, 63)), 1'b0);
                end
                4: begin
                    send_byte(8'(32'hc0 | $urandom_range(0, 31)), 1'b0);
                    send_byte(8'(32'h80 | $urandom_range(0, 63)), 1'b0);
                end
                5: begin
                    send_byte(CH_BSL, 1'b0);
                    send_byte(CH_U, 1'b0);
                    repeat (4) send_byte(rand_hex(), 1'b0);
                end
                6: begin
                    send_text_nc("\\ud", 1'b0);
                    send_byte($urandom_range(0, 1) ? "8" : "B", 1'b0);
                    repeat (2) send_byte(rand_hex(), 1'b0);
                    send_text_nc("\\udc", 1'b0);
                    repeat (2) send_byte(rand_hex(), 1'b0);
                end
                7: begin
                    send_byte(CH_BSL, 1'b0);
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                default: send_byte(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_random();
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_capacity(16'd65535);
                1: set_capacity(16'($urandom_range(2, 12)));
                2: set_capacity(16'd65535);
                default: begin
                    set_capacity(16'd65535);
                    idle_on = 1'b0;
                end
            endcase
            repeat (2) send_random_string();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_escapes();
        test_utf8();
        drain();
        test_capacity();
        test_random();
        drain();
        if (n_errors == 0 && expected_words.size() == 0) begin
            $display("json_string_unescape_utf8_core verification clean");
        end else begin
            $display("json_string_unescape_utf8_core verification failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("json_string_unescape_utf8_core verification failed");
        $finish;
    end
endmodule
